@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned PRIO_W        = 8;
  localparam int unsigned COUNT_W       = 4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_POP_RD,
    S_POP_MOV,
    S_HEAD_RD,
    S_HEAD_WAIT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [PRIO_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  head_data;
    logic [PRIO_W-1:0]  head_priority;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

endpackage
`default_nettype wire

@@ design/spq_if.sv @@
// Valid/ready channel interfaces for the queue's operation and result streams.
`default_nettype none
interface spq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [spq_pkg::DATA_W-1:0] item_data;
  logic [spq_pkg::PRIO_W-1:0] item_priority;

  modport source (output valid, func, item_data, item_priority, input ready);
  modport sink   (input valid, func, item_data, item_priority, output ready);
endinterface

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [spq_pkg::DATA_W-1:0]  head_data;
  logic [spq_pkg::PRIO_W-1:0]  head_priority;
  logic [spq_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, status, head_data, head_priority, entry_count, input ready);
  modport sink   (input valid, status, head_data, head_priority, entry_count, output ready);
endinterface
`default_nettype wire

@@ design/spq_store.sv @@
// Entry memory: one write port and one registered read port.
`default_nettype none
module spq_store #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire spq_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output spq_pkg::entry_t      rd_data_r
);

  spq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/spq_ctrl.sv @@
// Sequencer that walks the entry memory one slot per step with a shared rank compare.
`default_nettype none
module spq_ctrl #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_func,
  input  wire logic [spq_pkg::DATA_W-1:0] in_data,
  input  wire logic [spq_pkg::PRIO_W-1:0] in_prio,
  input  wire logic                       res_free,
  output logic                            res_load,
  output spq_pkg::result_t                res,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output spq_pkg::entry_t                 wr_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  input  wire spq_pkg::entry_t            rd_data
);

  spq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    k_r, k_nxt;
  spq_pkg::entry_t  new_r, new_nxt;
  spq_pkg::status_t status_r, status_nxt;
  logic             rank_lower;
  logic [CW+3:0]    cnt_ext;

  assign rank_lower = rd_data.rank < new_r.rank;
  assign cnt_ext    = {4'd0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    new_r    <= new_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    new_nxt    = new_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    res_load   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = k_r[AW-1:0];
    wr_data    = new_r;
    rd_en      = 1'b0;
    rd_addr    = AW'(k_r - CW'(1));
    res.status        = status_r;
    res.head_data     = (cnt_r != '0) ? rd_data.word : '0;
    res.head_priority = (cnt_r != '0) ? rd_data.rank : '0;
    res.entry_count   = cnt_ext[spq_pkg::COUNT_W-1:0];

    case (state_r)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          new_nxt.word = in_data;
          new_nxt.rank = in_prio;
          status_nxt   = spq_pkg::ST_DONE;
          if (in_func == spq_pkg::FUNC_INSERT) begin
            if (in_prio == '0) begin
              status_nxt = spq_pkg::ST_ZERO;
              state_nxt  = spq_pkg::S_HEAD_RD;
            end else if (cnt_r >= CW'(DEPTH)) begin
              status_nxt = spq_pkg::ST_FULL;
              state_nxt  = spq_pkg::S_HEAD_RD;
            end else begin
              k_nxt     = cnt_r;
              state_nxt = spq_pkg::S_INS_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = spq_pkg::ST_EMPTY;
              state_nxt  = spq_pkg::S_HEAD_RD;
            end else begin
              k_nxt     = CW'(1);
              state_nxt = spq_pkg::S_POP_RD;
            end
          end
        end
      end
      spq_pkg::S_INS_RD: begin
        if (k_r == '0) begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = spq_pkg::S_HEAD_RD;
        end else begin
          rd_en     = 1'b1;
          state_nxt = spq_pkg::S_INS_CMP;
        end
      end
      spq_pkg::S_INS_CMP: begin
        wr_en = 1'b1;
        if (rank_lower) begin
          wr_data   = rd_data;
          k_nxt     = k_r - CW'(1);
          state_nxt = spq_pkg::S_INS_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = spq_pkg::S_HEAD_RD;
        end
      end
      spq_pkg::S_POP_RD: begin
        if (k_r >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = spq_pkg::S_HEAD_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = k_r[AW-1:0];
          state_nxt = spq_pkg::S_POP_MOV;
        end
      end
      spq_pkg::S_POP_MOV: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(k_r - CW'(1));
        wr_data   = rd_data;
        k_nxt     = k_r + CW'(1);
        state_nxt = spq_pkg::S_POP_RD;
      end
      spq_pkg::S_HEAD_RD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = spq_pkg::S_HEAD_WAIT;
      end
      spq_pkg::S_HEAD_WAIT: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: sequencer, entry memory and result register.
//
// Usage: each transfer on in_ch is one operation. func = insert places
// item_data with item_priority behind all entries of equal or higher
// priority; func = remove drops the head entry. Every operation yields one
// transfer on out_ch carrying the status, the head entry after the
// operation (zero when empty) and the entry count.
// Timing: one operation at a time. An insert moves entries one by one
// from the tail toward the head until it finds its slot; a remove moves
// every entry after the head up by one; a rejected operation only reads
// the head. The memory has one write port and one read port, and each
// moved entry is read and then written back one slot over.
// in_ch.ready is high only while the sequencer is idle.
// Reset: the queue is empty, no result is pending, in_ch is ready.
// Stall: a finished result sits in the output register while out_ch.ready
// is low; the next operation is still taken and waits at its final step
// until the register frees.
`default_nettype none
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  spq_pkg::entry_t  wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  spq_pkg::entry_t  rd_data;
  logic             res_free;
  logic             res_load;
  spq_pkg::result_t res;
  logic             out_valid_r;
  spq_pkg::result_t out_res_r;

  assign res_free = !out_valid_r || out_ch.ready;

  spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_func  (in_ch.func),
    .in_data  (in_ch.item_data),
    .in_prio  (in_ch.item_priority),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  spq_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.head_data     = out_res_r.head_data;
  assign out_ch.head_priority = out_res_r.head_priority;
  assign out_ch.entry_count   = out_res_r.entry_count;

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the sorted priority queue: stimulus, prediction and checking.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH    = spq_pkg::DEPTH_DEFAULT;
  localparam int          RAND_OPS  = 1100;
  localparam int          HOLD_AT   = 300;
  localparam int          HOLD_LEN  = 400;
  localparam int          SETTLE    = 4 * QDEPTH + 10;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct {
    logic                       func;
    logic [spq_pkg::DATA_W-1:0] data;
    logic [spq_pkg::PRIO_W-1:0] prio;
    int                         gap;
    bit                         drain;
  } op_item_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(.DEPTH(QDEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  op_item_t          pending_ops[$];
  spq_pkg::result_t  expected_results[$];

  logic [spq_pkg::DATA_W-1:0] model_word[QDEPTH];
  logic [spq_pkg::PRIO_W-1:0] model_rank[QDEPTH];
  int                         model_fill;

  bit in_fire = 1'b0;
  int n_ops;
  int n_accepted;
  int n_checked;
  int n_errors;
  int st_seen[4];
  int full_hits;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [spq_pkg::PRIO_W-1:0] pick_rank();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 55) return (spq_pkg::PRIO_W)'($urandom_range(1, 4));
    if (r < 60) return '1;
    return (spq_pkg::PRIO_W)'($urandom_range(1, 255));
  endfunction

  function automatic spq_pkg::result_t queue_apply(logic op,
                                                   logic [spq_pkg::DATA_W-1:0] word,
                                                   logic [spq_pkg::PRIO_W-1:0] rank);
    spq_pkg::result_t r;
    int               pos;
    int               k;
    r.status = spq_pkg::ST_DONE;
    if (op == spq_pkg::FUNC_INSERT) begin
      if (rank == '0) begin
        r.status = spq_pkg::ST_ZERO;
      end else if (model_fill >= QDEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < model_fill && model_rank[pos] >= rank) pos++;
        for (k = model_fill; k > pos; k--) begin
          model_word[k] = model_word[k-1];
          model_rank[k] = model_rank[k-1];
        end
        model_word[pos] = word;
        model_rank[pos] = rank;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        for (k = 1; k < model_fill; k++) begin
          model_word[k-1] = model_word[k];
          model_rank[k-1] = model_rank[k];
        end
        model_fill--;
      end
    end
    r.head_data     = (model_fill > 0) ? model_word[0] : '0;
    r.head_priority = (model_fill > 0) ? model_rank[0] : '0;
    r.entry_count   = (spq_pkg::COUNT_W)'(model_fill);
    return r;
  endfunction

  task automatic add_op(logic op, logic [spq_pkg::DATA_W-1:0] data,
                        logic [spq_pkg::PRIO_W-1:0] prio, int gap, bit drain);
    op_item_t it;
    it.func  = op;
    it.data  = data;
    it.prio  = prio;
    it.gap   = gap;
    it.drain = drain;
    pending_ops.push_back(it);
    n_ops++;
  endtask

  // Driver: present operations at the falling edge.
  op_item_t cur_op;
  int       gap_left = 0;

  always @(negedge clk) begin
    logic nv;
    nv = in_ch.valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      nv = 1'b1;
    end else begin
      if (in_ch.valid && in_fire) gap_left = cur_op.gap;
      if (gap_left > 0) begin
        gap_left--;
        nv = 1'b0;
      end else if (pending_ops.size() == 0) begin
        nv = 1'b0;
      end else if (pending_ops[0].drain && expected_results.size() != 0) begin
        nv = 1'b0;
      end else begin
        cur_op = pending_ops.pop_front();
        in_ch.func          <= cur_op.func;
        in_ch.item_data     <= cur_op.data;
        in_ch.item_priority <= cur_op.prio;
        nv = 1'b1;
      end
    end
    in_ch.valid <= nv;
  end

  // Receiver: random back-pressure plus one long hold-off.
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  int  rx_wait = 0;
  bit  rx_calm = 1'b0;
  int  rx_phase = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase % 200 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_LEN - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_wait = rx_calm ? 0 : gap_len();
      end
    end
  end

  // Monitor: predict on each accepted operation, check each result transfer.
  always @(posedge clk) begin
    spq_pkg::result_t exp_r;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(queue_apply(in_ch.func, in_ch.item_data,
                                             in_ch.item_priority));
      n_accepted++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d head=%h/%h count=%0d", $time,
                 out_ch.status, out_ch.head_data, out_ch.head_priority, out_ch.entry_count);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        st_seen[exp_r.status]++;
        if (exp_r.entry_count == (spq_pkg::COUNT_W)'(QDEPTH)) full_hits++;
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   exp_r.status, out_ch.status);
          n_errors++;
        end
        if (out_ch.head_data !== exp_r.head_data) begin
          $display("%0t: head_data mismatch expected %h actual %h", $time,
                   exp_r.head_data, out_ch.head_data);
          n_errors++;
        end
        if (out_ch.head_priority !== exp_r.head_priority) begin
          $display("%0t: head_priority mismatch expected %h actual %h", $time,
                   exp_r.head_priority, out_ch.head_priority);
          n_errors++;
        end
        if (out_ch.entry_count !== exp_r.entry_count) begin
          $display("%0t: entry_count mismatch expected %0d actual %0d", $time,
                   exp_r.entry_count, out_ch.entry_count);
          n_errors++;
        end
      end
    end
  end

  initial begin
    mix_t mix;
    int   blk;
    int   ins_pct;
    bit   burst;
    bit   first_rand;
    int   i;
    logic op;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = spq_pkg::FUNC_INSERT;
    in_ch.item_data     = '0;
    in_ch.item_priority = '0;
    out_ch.ready        = 1'b0;
    model_fill          = 0;
    n_ops = 0; n_accepted = 0; n_checked = 0; n_errors = 0; full_hits = 0;
    for (i = 0; i < 4; i++) st_seen[i] = 0;

    add_op(spq_pkg::FUNC_REMOVE, 16'hBEEF, 8'h33, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'hFFFF, 8'h00, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'hFFFF, 8'hFF, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h0000, 8'h01, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h1234, 8'h80, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h5678, 8'h80, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h9ABC, 8'h80, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h0001, 8'hFF, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'hA5A5, 8'h01, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h5A5A, 8'h02, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h7777, 8'h10, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h0000, 8'h00, 0, 1'b0);
    for (i = 0; i < QDEPTH; i++) add_op(spq_pkg::FUNC_REMOVE, 16'hFFFF, 8'hFF, 0, 1'b0);
    add_op(spq_pkg::FUNC_REMOVE, 16'h0000, 8'h00, 0, 1'b0);
    add_op(spq_pkg::FUNC_INSERT, 16'h4321, 8'h7F, 0, 1'b0);
    add_op(spq_pkg::FUNC_REMOVE, 16'hC3C3, 8'h5A, 0, 1'b0);

    first_rand = 1'b1;
    while (n_ops < RAND_OPS + 23) begin
      mix   = mix_t'($urandom_range(0, 2));
      burst = ($urandom_range(0, 3) == 0);
      blk   = $urandom_range(20, 60);
      case (mix)
        MIX_FILL:  ins_pct = 75;
        MIX_DRAIN: ins_pct = 30;
        default:   ins_pct = 55;
      endcase
      for (i = 0; i < blk; i++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::FUNC_INSERT
                                                : spq_pkg::FUNC_REMOVE;
        add_op(op, (spq_pkg::DATA_W)'($urandom_range(0, 65535)), pick_rank(),
               burst ? 0 : gap_len(),
               first_rand || (i == 0 && $urandom_range(0, 9) == 0));
        first_rand = 1'b0;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_ops.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("tb: %0d operations transferred, %0d results checked, queue full %0d times",
             n_accepted, n_checked, full_hits);
    $display("tb: status done=%0d full=%0d zero=%0d empty=%0d",
             st_seen[spq_pkg::ST_DONE], st_seen[spq_pkg::ST_FULL],
             st_seen[spq_pkg::ST_ZERO], st_seen[spq_pkg::ST_EMPTY]);
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
